// ----- rtl/acbc_pkg.sv -----
// AES-CBC cipher package: payload structs, S-box tables and round helper functions.
// Standalone; imported by aes_cbc_cipher.
`default_nettype none

package acbc_pkg;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        last_block;
      logic [4:0]  valid_bytes;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
      logic [4:0]  kept_bytes;
      logic        last_result;
      logic        padding_error;
   } rsp_type;

   localparam int unsigned NUM_REGS = 8;
   localparam logic [2:0] REG_KEY0  = 3'd0;
   localparam logic [2:0] REG_KEY1  = 3'd1;
   localparam logic [2:0] REG_KEY2  = 3'd2;
   localparam logic [2:0] REG_KEY3  = 3'd3;
   localparam logic [2:0] REG_K256  = 3'd4;
   localparam logic [2:0] REG_IVH   = 3'd5;
   localparam logic [2:0] REG_IVL   = 3'd6;
   localparam logic [2:0] REG_MODE  = 3'd7;

   localparam logic [3:0] NR_128 = 4'd10;
   localparam logic [3:0] NR_256 = 4'd14;
   localparam logic [4:0] FULL_BLOCK = 5'd16;

   localparam logic [2047:0] SBOX_BITS = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_BITS = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] b);
      return SBOX_BITS[2047 - 8 * int'(b) -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] b);
      return INV_SBOX_BITS[2047 - 8 * int'(b) -: 8];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0: r = 8'h01;
         4'd1: r = 8'h02;
         4'd2: r = 8'h04;
         4'd3: r = 8'h08;
         4'd4: r = 8'h10;
         4'd5: r = 8'h20;
         4'd6: r = 8'h40;
         4'd7: r = 8'h80;
         4'd8: r = 8'h1b;
         4'd9: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte j of a 128-bit state, byte 0 on top
   function automatic logic [7:0] byte_at(input logic [127:0] s, input int j);
      return s[127 - 8 * j -: 8];
   endfunction

   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
      logic [127:0] sr;
      logic [127:0] mc;
      logic [7:0]   a0, a1, a2, a3, t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sr[127 - 8 * (r + 4 * c) -: 8] = sbox(byte_at(s, r + 4 * ((c + r) & 3)));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = byte_at(sr, 4 * c);
         a1 = byte_at(sr, 4 * c + 1);
         a2 = byte_at(sr, 4 * c + 2);
         a3 = byte_at(sr, 4 * c + 3);
         t  = a0 ^ a1 ^ a2 ^ a3;
         mc[127 - 32 * c -: 32] = {a0 ^ t ^ xt(a0 ^ a1), a1 ^ t ^ xt(a1 ^ a2),
                                   a2 ^ t ^ xt(a2 ^ a3), a3 ^ t ^ xt(a3 ^ a0)};
      end
      return last ? sr : mc;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] m;
      logic [7:0]   a [4];
      logic [7:0]   x2 [4];
      logic [7:0]   x4 [4];
      logic [7:0]   x8 [4];
      logic [7:0]   m9 [4];
      logic [7:0]   mb [4];
      logic [7:0]   md [4];
      logic [7:0]   me [4];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = byte_at(s, 4 * c + k);
            x2[k] = xt(a[k]);
            x4[k] = xt(x2[k]);
            x8[k] = xt(x4[k]);
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
         end
         m[127 - 32 * c -: 32] = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                                  m9[0] ^ me[1] ^ mb[2] ^ md[3],
                                  md[0] ^ m9[1] ^ me[2] ^ mb[3],
                                  mb[0] ^ md[1] ^ m9[2] ^ me[3]};
      end
      return m;
   endfunction

   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = inv_sbox(byte_at(s, r + 4 * c));
         end
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/aes_cbc_cipher.sv -----
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//  csr     | in/out    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
// A block passes through an initial key add (S_INIT), nr rounds and a hand-off (S_FINISH):
// one round per cycle through a single shared round unit fed from the key row memory.
// The first block after a key change waits while 11 or 15 key rows expand, one per cycle.
// A full final block in padded encrypt makes a second pass for the pad block.
// Synchronous active-high reset clears control; the key memory is not cleared.
// req_ready stays low while a block is in the round unit or its result cannot be stored.
// AES-128/256 CBC cipher with PKCS#7 padding handling.
// Depends on acbc_pkg.
`default_nettype none

module aes_cbc_cipher
   import acbc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [5:0]    paddr,
   input  wire logic [63:0]   pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_KEXP   = 5'b00010,
      S_INIT   = 5'b00100,
      S_ROUND  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [63:0]   key_ff [4];
   logic          k256_ff;
   logic [63:0]   ivh_ff, ivl_ff;
   logic [1:0]    mode_ff;
   logic          keys_ready_ff, keys_ready_in;
   logic          msg_start_ff, msg_start_in;
   logic [127:0]  chain_ff, chain_in;
   logic [127:0]  blk_ff, blk_in;
   logic [127:0]  prev_ff, prev_in;
   logic [127:0]  s_ff, s_in;
   logic          dec_ff, dec_in;
   logic          pad_ff, pad_in;
   logic          last_ff, last_in;
   logic          pend_ff, pend_in;
   logic [3:0]    kr_ff, kr_in;
   logic [3:0]    ki_ff;
   logic [127:0]  prev1_ff, prev1_in;
   logic [127:0]  prev2_ff, prev2_in;
   logic [127:0]  rk_mem [15];
   logic [127:0]  rk_q_ff;
   logic [3:0]    raddr;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          wr_en;
   logic [2:0]    widx;
   logic [3:0]    nr;
   logic          req_fire;
   logic          key_write;
   logic          out_free;
   logic          last_round;
   logic          kx_we;
   logic [127:0]  kx_row;

   assign pready   = 1'b1;
   assign widx     = paddr[5:3];
   assign wr_en    = psel && penable && pwrite && pready;
   assign key_write = wr_en && (widx == REG_KEY0 || widx == REG_KEY1 || widx == REG_KEY2 ||
                                widx == REG_KEY3 || widx == REG_K256);
   assign nr       = k256_ff ? NR_256 : NR_128;
   assign req_ready = (state_ff == S_IDLE) && keys_ready_ff;
   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_round = dec_ff ? (ki_ff == 4'd0) : (ki_ff == nr);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         k256_ff <= 1'b0;
         ivh_ff  <= '0;
         ivl_ff  <= '0;
         mode_ff <= '0;
      end else if (wr_en) begin
         case (widx)
            REG_KEY0: key_ff[0] <= pwdata;
            REG_KEY1: key_ff[1] <= pwdata;
            REG_KEY2: key_ff[2] <= pwdata;
            REG_KEY3: key_ff[3] <= pwdata;
            REG_K256: k256_ff   <= pwdata[0];
            REG_IVH:  ivh_ff    <= pwdata;
            REG_IVL:  ivl_ff    <= pwdata;
            REG_MODE: mode_ff   <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         REG_KEY0: prdata = key_ff[0];
         REG_KEY1: prdata = key_ff[1];
         REG_KEY2: prdata = key_ff[2];
         REG_KEY3: prdata = key_ff[3];
         REG_K256: prdata = {63'd0, k256_ff};
         REG_IVH:  prdata = ivh_ff;
         REG_IVL:  prdata = ivl_ff;
         REG_MODE: prdata = {62'd0, mode_ff};
         default:  prdata = '0;
      endcase
   end

   // key expansion: one 128-bit row per cycle
   always_comb begin
      logic [31:0]  lastw, rotw, t0, w0, w1, w2, w3;
      logic         no_rot;
      logic [3:0]   ridx;
      logic [127:0] base;
      no_rot = k256_ff && kr_ff[0];
      lastw  = prev1_ff[31:0];
      rotw   = no_rot ? lastw : {lastw[23:0], lastw[31:24]};
      ridx   = k256_ff ? ({1'b0, kr_ff[3:1]} - 4'd1) : (kr_ff - 4'd1);
      t0     = sub_word(rotw) ^ (no_rot ? 32'd0 : {rcon(ridx), 24'd0});
      base   = k256_ff ? prev2_ff : prev1_ff;
      w0     = base[127:96] ^ t0;
      w1     = base[95:64] ^ w0;
      w2     = base[63:32] ^ w1;
      w3     = base[31:0] ^ w2;
      if (kr_ff == 4'd0) begin
         kx_row = {key_ff[0], key_ff[1]};
      end else if (kr_ff == 4'd1 && k256_ff) begin
         kx_row = {key_ff[2], key_ff[3]};
      end else begin
         kx_row = {w0, w1, w2, w3};
      end
   end

   assign kx_we = (state_ff == S_KEXP) && !key_write;

   always_ff @(posedge clock) begin
      if (kx_we) rk_mem[kr_ff] <= kx_row;
      rk_q_ff <= rk_mem[raddr];
   end

   // key row to read for the next cycle
   always_comb begin
      if (state_ff == S_IDLE) begin
         raddr = mode_ff[0] ? nr : 4'd0;
      end else if (state_ff == S_FINISH) begin
         raddr = dec_ff ? nr : 4'd0;
      end else begin
         raddr = dec_ff ? (ki_ff - 4'd1) : (ki_ff + 4'd1);
      end
   end

   always_comb begin
      logic [127:0] res, inv_a, eff_chain;
      logic [4:0]   vb, kept;
      logic [7:0]   padb, p;
      logic         ok;

      state_in      = state_ff;
      keys_ready_in = keys_ready_ff;
      msg_start_in  = msg_start_ff;
      chain_in      = chain_ff;
      blk_in        = blk_ff;
      prev_in       = prev_ff;
      s_in          = s_ff;
      dec_in        = dec_ff;
      pad_in        = pad_ff;
      last_in       = last_ff;
      pend_in       = pend_ff;
      kr_in         = kr_ff;
      prev1_in      = prev1_ff;
      prev2_in      = prev2_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      res   = dec_ff ? (s_ff ^ prev_ff) : s_ff;
      inv_a = inv_shift_sub(s_ff) ^ rk_q_ff;
      eff_chain = msg_start_ff ? {ivh_ff, ivl_ff} : chain_ff;
      vb    = (req_data.valid_bytes > FULL_BLOCK) ? FULL_BLOCK : req_data.valid_bytes;
      padb  = {3'd0, FULL_BLOCK - vb};

      // PKCS#7 check on the decrypted block
      p  = res[7:0];
      ok = (p >= 8'd1) && (p <= 8'd16);
      for (int i = 0; i < 16; i++) begin
         if ((6'(i) + {1'b0, p[4:0]} >= 6'd16) && (byte_at(res, i) != p)) ok = 1'b0;
      end
      if (dec_ff && pad_ff && last_ff) begin
         kept = ok ? (FULL_BLOCK - p[4:0]) : 5'd0;
      end else begin
         kept = FULL_BLOCK;
      end

      case (state_ff)
         S_IDLE: begin
            kr_in = 4'd0;
            if (req_valid && !keys_ready_ff) begin
               state_in = S_KEXP;
            end else if (req_fire) begin
               dec_in       = mode_ff[0];
               pad_in       = mode_ff[1];
               last_in      = req_data.last_block;
               msg_start_in = req_data.last_block;
               prev_in      = eff_chain;
               blk_in       = {req_data.block_high, req_data.block_low};
               pend_in      = 1'b0;
               if (mode_ff[0]) begin
                  chain_in = {req_data.block_high, req_data.block_low};
               end else if (mode_ff[1] && req_data.last_block) begin
                  if (vb == FULL_BLOCK) begin
                     pend_in = 1'b1;
                  end else begin
                     for (int i = 0; i < 16; i++) begin
                        if (5'(i) >= vb) blk_in[127 - 8 * i -: 8] = padb;
                     end
                  end
               end
               state_in = S_INIT;
            end
         end
         S_KEXP: begin
            prev1_in = kx_row;
            prev2_in = prev1_ff;
            kr_in    = kr_ff + 4'd1;
            if (kr_ff == nr) begin
               keys_ready_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_INIT: begin
            s_in     = dec_ff ? (blk_ff ^ rk_q_ff) : (blk_ff ^ prev_ff ^ rk_q_ff);
            state_in = S_ROUND;
         end
         S_ROUND: begin
            if (dec_ff) begin
               s_in = last_round ? inv_a : inv_mix(inv_a);
            end else begin
               s_in = enc_round(s_ff, last_round) ^ rk_q_ff;
            end
            if (last_round) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.result_high    = res[127:64];
               rsp_in.result_low     = res[63:0];
               rsp_in.kept_bytes     = kept;
               rsp_in.last_result    = pend_ff ? 1'b0 : last_ff;
               rsp_in.padding_error  = dec_ff && pad_ff && last_ff && !ok;
               if (!dec_ff) chain_in = s_ff;
               if (pend_ff) begin
                  // second pass: a whole pad block chained on the first ciphertext
                  pend_in  = 1'b0;
                  blk_in   = {16{8'h10}};
                  prev_in  = s_ff;
                  state_in = S_INIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (key_write) begin
         keys_ready_in = 1'b0;
         if (state_ff == S_KEXP) state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         keys_ready_ff <= 1'b0;
         msg_start_ff  <= 1'b1;
         chain_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         kr_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
         msg_start_ff  <= msg_start_in;
         chain_ff      <= chain_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
         kr_ff         <= kr_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff   <= blk_in;
      prev_ff  <= prev_in;
      s_ff     <= s_in;
      dec_ff   <= dec_in;
      pad_ff   <= pad_in;
      last_ff  <= last_in;
      prev1_ff <= prev1_in;
      prev2_ff <= prev2_in;
      rsp_ff   <= rsp_in;
      ki_ff    <= raddr;
   end

`ifndef SYNTHESIS
   a_fire_init: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_INIT)
      else $error("accepted beat did not start a pass");

   a_round_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND |-> ki_ff <= nr)
      else $error("round key index out of range");

   a_pad_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.padding_error |-> rsp_ff.kept_bytes == 5'd0 && rsp_ff.last_result)
      else $error("padding error without zero kept bytes on last beat");
`endif

endmodule

`default_nettype wire

// ----- sim/aes_cbc_cipher_tb.sv -----
// Testbench for aes_cbc_cipher: AES-128/256 CBC with PKCS#7 padding, checked
// against an in-bench cipher model per beat. Depends on acbc_pkg and aes_cbc_cipher.
`default_nettype none

module aes_cbc_cipher_tb;
   import acbc_pkg::*;

   localparam logic [1:0] MODE_ENC     = 2'b00;
   localparam logic [1:0] MODE_DEC     = 2'b01;
   localparam logic [1:0] MODE_ENC_PAD = 2'b10;
   localparam logic [1:0] MODE_DEC_PAD = 2'b11;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [5:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   aes_cbc_cipher i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // cipher model state
   logic [7:0]   fwd_sbox [256];
   logic [7:0]   rev_sbox [256];
   logic [63:0]  key_reg [4];
   logic         wide_key;
   logic [63:0]  iv_hi, iv_lo;
   logic [1:0]   cur_mode;
   logic [31:0]  sched [60];
   logic [127:0] chain;
   logic         at_msg_start;
   logic         sched_ok;

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      rx_hold = 0;
   int      rx_gap = 0;
   bit      no_gaps = 0;
   int      quiet_cnt = 0;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] m);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (m[i]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
      return (x << n) | (x >> (8 - n));
   endfunction

   function automatic logic [31:0] sub32(input logic [31:0] w);
      return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
   endfunction

   function automatic void expand_round_keys();
      int nk, total;
      logic [31:0] t;
      logic [7:0] rc;
      nk = wide_key ? 8 : 4;
      total = wide_key ? 60 : 44;
      for (int i = 0; i < nk; i++)
         sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
      rc = 8'h01;
      for (int i = nk; i < total; i++) begin
         t = sched[i - 1];
         if (i % nk == 0) begin
            t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gf_mul(rc, 8'h02);
         end else if (nk == 8 && i % nk == 4) begin
            t = sub32(t);
         end
         sched[i] = sched[i - nk] ^ t;
      end
   endfunction

   function automatic logic [127:0] round_key(input int r);
      return {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
   endfunction

   function automatic logic [127:0] aes_fwd(input logic [127:0] s);
      int nr;
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      nr = wide_key ? 14 : 10;
      s ^= round_key(0);
      for (int r = 1; r <= nr; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               t[127 - 8 * (w + 4 * c) -: 8] = fwd_sbox[s[127 - 8 * (w + 4 * ((c + w) & 3)) -: 8]];
         if (r != nr) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[127 - 32 * c -: 8];
               a1 = t[119 - 32 * c -: 8];
               a2 = t[111 - 32 * c -: 8];
               a3 = t[103 - 32 * c -: 8];
               t[127 - 32 * c -: 32] = {
                  gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3,
                  a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3,
                  a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03),
                  gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02)};
            end
         end
         s = t ^ round_key(r);
      end
      return s;
   endfunction

   function automatic logic [127:0] aes_inv(input logic [127:0] s);
      int nr;
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      nr = wide_key ? 14 : 10;
      s ^= round_key(nr);
      for (int r = nr - 1; r >= 0; r--) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               t[127 - 8 * (w + 4 * ((c + w) & 3)) -: 8] = rev_sbox[s[127 - 8 * (w + 4 * c) -: 8]];
         t ^= round_key(r);
         if (r != 0) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[127 - 32 * c -: 8];
               a1 = t[119 - 32 * c -: 8];
               a2 = t[111 - 32 * c -: 8];
               a3 = t[103 - 32 * c -: 8];
               t[127 - 32 * c -: 32] = {
                  gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b) ^ gf_mul(a2, 8'h0d) ^ gf_mul(a3, 8'h09),
                  gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e) ^ gf_mul(a2, 8'h0b) ^ gf_mul(a3, 8'h0d),
                  gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09) ^ gf_mul(a2, 8'h0e) ^ gf_mul(a3, 8'h0b),
                  gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d) ^ gf_mul(a2, 8'h09) ^ gf_mul(a3, 8'h0e)};
            end
         end
         s = t;
      end
      return s;
   endfunction

   function automatic void push_rsp(input logic [127:0] b, input logic [4:0] kept,
                                    input logic lst, input logic err);
      rsp_type e;
      e.result_high = b[127:64];
      e.result_low = b[63:0];
      e.kept_bytes = kept;
      e.last_result = lst;
      e.padding_error = err;
      pending_rsp.push_back(e);
   endfunction

   // model one accepted request beat
   function automatic void cipher_item(input req_type d);
      logic [4:0] vb;
      logic [127:0] b, p;
      logic [7:0] pb;
      logic ok;
      logic [4:0] kept;
      vb = (d.valid_bytes > 5'd16) ? 5'd16 : d.valid_bytes;
      if (!sched_ok) begin
         expand_round_keys();
         sched_ok = 1'b1;
      end
      if (at_msg_start) begin
         chain = {iv_hi, iv_lo};
         at_msg_start = 1'b0;
      end
      b = {d.block_high, d.block_low};
      if (!cur_mode[0]) begin
         if (cur_mode[1] && d.last_block && vb == 5'd16) begin
            chain = aes_fwd(b ^ chain);
            push_rsp(chain, 5'd16, 1'b0, 1'b0);
            chain = aes_fwd({16{8'h10}} ^ chain);
            push_rsp(chain, 5'd16, 1'b1, 1'b0);
         end else begin
            if (cur_mode[1] && d.last_block)
               for (int j = 0; j < 16; j++)
                  if (j >= vb) b[127 - 8 * j -: 8] = 8'(16 - vb);
            chain = aes_fwd(b ^ chain);
            push_rsp(chain, 5'd16, d.last_block, 1'b0);
         end
      end else begin
         p = aes_inv(b) ^ chain;
         chain = b;
         kept = 5'd16;
         ok = 1'b1;
         if (cur_mode[1] && d.last_block) begin
            pb = p[7:0];
            ok = (pb >= 1 && pb <= 16);
            if (ok)
               for (int j = 0; j < 16; j++)
                  if (j >= 16 - pb && p[127 - 8 * j -: 8] != pb) ok = 1'b0;
            kept = ok ? 5'(16 - pb) : 5'd0;
         end
         push_rsp(p, kept, d.last_block, !ok);
      end
      if (d.last_block) at_msg_start = 1'b1;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.result_high !== e.result_high) begin
               $error("result_high exp %h got %h", e.result_high, rsp_data.result_high);
               errors++;
            end
            if (rsp_data.result_low !== e.result_low) begin
               $error("result_low exp %h got %h", e.result_low, rsp_data.result_low);
               errors++;
            end
            if (rsp_data.kept_bytes !== e.kept_bytes) begin
               $error("kept_bytes exp %0d got %0d", e.kept_bytes, rsp_data.kept_bytes);
               errors++;
            end
            if (rsp_data.last_result !== e.last_result) begin
               $error("last_result exp %b got %b", e.last_result, rsp_data.last_result);
               errors++;
            end
            if (rsp_data.padding_error !== e.padding_error) begin
               $error("padding_error exp %b got %b", e.padding_error, rsp_data.padding_error);
               errors++;
            end
         end
      end
   end

   // receiver: random stalls, occasional long ones, plus a forced hold-off
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (rx_hold > 0) begin
         rsp_ready <= 1'b0;
         rx_hold--;
      end else if (no_gaps) begin
         rsp_ready <= 1'b1;
      end else if (rx_gap > 0) begin
         rsp_ready <= 1'b0;
         rx_gap--;
      end else begin
         if (r < 3) rx_gap = $urandom_range(10, 40);
         rsp_ready <= (r >= 25);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cnt = 0;
      else quiet_cnt++;
      if (quiet_cnt >= STALL_LIMIT) begin
         $display("FAIL aes_cbc_cipher");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [63:0] rand64();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 64'h0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(input req_type d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (!req_ready);
      cipher_item(d);
   endtask

   // let every expected beat arrive, then allow the block to go fully idle
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_KEY0: begin key_reg[0] = v; sched_ok = 1'b0; end
         REG_KEY1: begin key_reg[1] = v; sched_ok = 1'b0; end
         REG_KEY2: begin key_reg[2] = v; sched_ok = 1'b0; end
         REG_KEY3: begin key_reg[3] = v; sched_ok = 1'b0; end
         REG_K256: begin wide_key = v[0]; sched_ok = 1'b0; end
         REG_IVH: iv_hi = v;
         REG_IVL: iv_lo = v;
         REG_MODE: cur_mode = v[1:0];
         default: ;
      endcase
   endtask

   task automatic load_setup(input logic k256, input logic [1:0] md);
      csr_write(REG_KEY0, rand64());
      csr_write(REG_KEY1, rand64());
      csr_write(REG_KEY2, rand64());
      csr_write(REG_KEY3, rand64());
      csr_write(REG_K256, {63'h0, k256});
      csr_write(REG_IVH, rand64());
      csr_write(REG_IVL, rand64());
      csr_write(REG_MODE, {62'h0, md});
   endtask

   task automatic send_block(input logic [127:0] b, input logic lst, input logic [4:0] vb);
      req_type d;
      d.block_high = b[127:64];
      d.block_low = b[63:0];
      d.last_block = lst;
      d.valid_bytes = vb;
      send_item(d);
   endtask

   // ciphertext block whose padded-decrypt plaintext is pt, chained from the model
   function automatic logic [127:0] craft_ct(input logic [127:0] pt, input logic [127:0] prev);
      if (!sched_ok) begin
         expand_round_keys();
         sched_ok = 1'b1;
      end
      return aes_fwd(pt ^ prev);
   endfunction

   function automatic logic [127:0] pad_block(input logic [127:0] b, input int p);
      for (int j = 16 - p; j < 16; j++) b[127 - 8 * j -: 8] = 8'(p);
      return b;
   endfunction

   task automatic send_padded_dec_msg(input int n, input int p);
      logic [127:0] prev, pt, ct;
      prev = at_msg_start ? {iv_hi, iv_lo} : chain;
      for (int i = 0; i < n; i++) begin
         pt = {rand64(), rand64()};
         if (i == n - 1) pt = pad_block(pt, p);
         ct = craft_ct(pt, prev);
         prev = ct;
         send_block(ct, i == n - 1, 5'($urandom_range(0, 31)));
      end
   endtask

   task automatic test_directed();
      logic [127:0] ct, pt;
      csr_write(REG_KEY0, 64'h0001020304050607);
      csr_write(REG_KEY1, 64'h08090a0b0c0d0e0f);
      csr_write(REG_KEY2, 64'h1011121314151617);
      csr_write(REG_KEY3, 64'h18191a1b1c1d1e1f);
      csr_write(REG_IVH, 64'h0);
      csr_write(REG_IVL, 64'h0);
      csr_write(REG_MODE, {62'h0, MODE_ENC});
      send_block(128'h00112233445566778899aabbccddeeff, 1'b1, 5'd0);
      send_block('0, 1'b0, 5'd31);
      send_block('1, 1'b1, 5'd16);
      settle();
      csr_write(REG_K256, 64'h1);
      csr_write(REG_MODE, {62'h0, MODE_DEC});
      send_block(128'h8ea2b7ca516745bfeafc49904b496089, 1'b1, 5'd0);
      send_block('1, 1'b0, 5'd0);
      send_block('0, 1'b1, 5'd0);
      settle();
      // padded encrypt: zero, partial, full and oversized valid byte counts
      csr_write(REG_MODE, {62'h0, MODE_ENC_PAD});
      csr_write(REG_IVH, '1);
      csr_write(REG_IVL, '1);
      send_block('1, 1'b1, 5'd0);
      send_block('0, 1'b1, 5'd1);
      send_block('1, 1'b1, 5'd15);
      send_block('0, 1'b1, 5'd16);
      send_block('1, 1'b0, 5'd3);
      send_block('1, 1'b1, 5'd17);
      send_block('0, 1'b1, 5'd31);
      settle();
      // padded decrypt: good pads of 1, 16, 5, then bad pads
      csr_write(REG_K256, 64'h0);
      csr_write(REG_MODE, {62'h0, MODE_DEC_PAD});
      send_padded_dec_msg(1, 1);
      send_padded_dec_msg(1, 16);
      send_padded_dec_msg(2, 5);
      pt = {120'h0, 8'h00};
      ct = craft_ct(pt, {iv_hi, iv_lo});
      send_block(ct, 1'b1, 5'd0);
      pt = {120'h0, 8'h11};
      ct = craft_ct(pt, {iv_hi, iv_lo});
      send_block(ct, 1'b1, 5'd0);
      pt = {112'h0, 16'h0404};
      ct = craft_ct(pt, {iv_hi, iv_lo});
      send_block(ct, 1'b1, 5'd0);
      settle();
   endtask

   task automatic test_random(input int phases);
      int n, msgs;
      logic [1:0] md;
      for (int ph = 0; ph < phases; ph++) begin
         md = 2'(ph);
         no_gaps = ($urandom_range(0, 5) == 0);
         load_setup(ph[2], md);
         msgs = $urandom_range(12, 22);
         for (int m = 0; m < msgs; m++) begin
            n = $urandom_range(1, 6);
            if (md == MODE_DEC_PAD && $urandom_range(0, 9) < 8) begin
               send_padded_dec_msg(n, $urandom_range(1, 16));
            end else begin
               for (int i = 0; i < n; i++)
                  send_block({rand64(), rand64()},
                             (i == n - 1) || ($urandom_range(0, 19) == 0),
                             ($urandom_range(0, 2) == 0) ? 5'd16 : 5'($urandom_range(0, 31)));
            end
         end
         settle();
      end
      no_gaps = 0;
   endtask

   task automatic test_backpressure();
      load_setup(1'b1, MODE_ENC_PAD);
      no_gaps = 1;
      rx_hold = 300;
      for (int i = 0; i < 40; i++)
         send_block({rand64(), rand64()}, 1'($urandom_range(0, 1)),
                    5'($urandom_range(0, 31)));
      no_gaps = 0;
      settle();
   endtask

   initial begin
      for (int i = 0; i < 256; i++) begin
         logic [7:0] inv, x;
         inv = 8'h01;
         for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(i));
         x = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
         fwd_sbox[i] = x;
         rev_sbox[x] = 8'(i);
      end
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      wide_key = 1'b0;
      iv_hi = '0;
      iv_lo = '0;
      cur_mode = MODE_ENC;
      chain = '0;
      at_msg_start = 1'b1;
      sched_ok = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(28);
      settle();
      if (errors == 0) $display("PASS aes_cbc_cipher");
      else $display("FAIL aes_cbc_cipher");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/acbc_pkg.sv
rtl/aes_cbc_cipher.sv
sim/aes_cbc_cipher_tb.sv
